@@ sv/spq_pkg.sv @@
// Shared types, sizes and codes for the sorted priority queue.
package spq_pkg;

  // Number of cells in the chain, one held entry per cell.
  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int PRIO_W = 8;
  localparam int DATA_W = 32;

  // Operation codes carried on the input tuser.
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // Result status codes carried on the output tuser.
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // One stored entry.
  typedef struct packed {
    logic [PRIO_W-1:0]        prio;
    logic signed [DATA_W-1:0] data;
  } entry_t;

  // Operation broadcast to every cell in the cycle of a transfer.
  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic [PRIO_W-1:0]        prio;
    logic signed [DATA_W-1:0] data;
  } cell_op_t;

endpackage

@@ sv/sorted_priority_queue.sv @@
// Top level of the sorted priority queue: chain of cells, counter and result register.
// A bounded priority queue of spq_pkg::DEPTH entries held in a row of cells, kept in
// ascending priority order with the head in the first cell; equal priorities leave in
// arrival order. Every transfer on the input (tuser 0 insert, 1 remove) yields exactly
// one result, offered on the output from the next cycle and held until it is taken:
// status 0 done, 1 insert refused because the queue is full, 2 remove on an empty
// queue, with the removed entry (zeros otherwise) and the count held afterwards. All
// cells compare the new priority against their own entry and shift in parallel, so a
// new item is taken in every cycle in which the result register is empty or being
// drained.
module sorted_priority_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [7:0] priority_req, [39:8] payload
  input  logic        s_tuser,   // [0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [7:0] out_priority, [39:8] out_payload,
                                 // [44:40] fill_count, [47:45] zero
  output logic [1:0]  m_tuser    // [1:0] status
);

  localparam int N = spq_pkg::DEPTH;

  logic                       accept;
  logic                       is_rem;
  logic                       full;
  logic                       empty;
  logic [spq_pkg::CNT_W-1:0]  count;
  logic [spq_pkg::CNT_W-1:0]  count_next;
  spq_pkg::cell_op_t          op;
  logic [N-1:0]               keep;
  logic [N-1:0]               valid;
  spq_pkg::entry_t            entry [N];
  logic [1:0]                 status;
  logic [1:0]                 status_next;
  spq_pkg::entry_t            res;
  spq_pkg::entry_t            res_next;

  // The result register parts the two sides.
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign is_rem   = (s_tuser == spq_pkg::KIND_REMOVE);
  assign full     = (count == spq_pkg::CNT_W'(N));
  assign empty    = (count == '0);

  // Operation for the cells, gated by the full and empty checks.
  always_comb begin
    op.ins  = accept && !is_rem && !full;
    op.rem  = accept && is_rem && !empty;
    op.prio = s_tdata[7:0];
    op.data = s_tdata[39:8];
  end

  // Chain of cells; the head cell sees a keeping, valid neighbor on its left.
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic            lk;
    logic            lv;
    spq_pkg::entry_t le;
    logic            rv;
    spq_pkg::entry_t re;
    if (i == 0) begin : g_head
      assign lk = 1'b1;
      assign lv = 1'b1;
      assign le = '0;
    end else begin : g_mid
      assign lk = keep[i-1];
      assign lv = valid[i-1];
      assign le = entry[i-1];
    end
    if (i == N - 1) begin : g_tail
      assign rv = 1'b0;
      assign re = '0;
    end else begin : g_body
      assign rv = valid[i+1];
      assign re = entry[i+1];
    end
    spq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .op          (op),
      .left_keep   (lk),
      .left_valid  (lv),
      .left_entry  (le),
      .right_valid (rv),
      .right_entry (re),
      .keep        (keep[i]),
      .valid       (valid[i]),
      .entry       (entry[i])
    );
  end

  // Result of the operation being taken.
  always_comb begin
    count_next  = count;
    status_next = spq_pkg::ST_DONE;
    res_next    = '0;
    if (is_rem) begin
      if (empty) begin
        status_next = spq_pkg::ST_EMPTY;
      end else begin
        count_next = count - spq_pkg::CNT_W'(1);
        res_next   = entry[0];
      end
    end else begin
      if (full) begin
        status_next = spq_pkg::ST_FULL;
      end else begin
        count_next = count + spq_pkg::CNT_W'(1);
      end
    end
  end

  // Entry count and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
      end
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
      res    <= res_next;
    end
  end

  assign m_tuser = status;
  assign m_tdata = {3'b000, count, res.data, res.prio};

endmodule

@@ sv/spq_cell.sv @@
// One cell of the sorted chain: holds a single entry and trades it with its neighbors.
module spq_cell (
  input  logic              clk,
  input  logic              rst,
  input  spq_pkg::cell_op_t op,
  input  logic              left_keep,
  input  logic              left_valid,
  input  spq_pkg::entry_t   left_entry,
  input  logic              right_valid,
  input  spq_pkg::entry_t   right_entry,
  output logic              keep,
  output logic              valid,
  output spq_pkg::entry_t   entry
);

  // An entry stays in place on insert when it sorts at or before the new one.
  assign keep = valid && (entry.prio <= op.prio);

  // Valid bit: the chain fills from the head like a thermometer.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (op.ins) begin
      valid <= valid | left_valid;
    end else if (op.rem) begin
      valid <= right_valid;
    end
  end

  // Entry: hold, take the new entry, or shift with a neighbor.
  always_ff @(posedge clk) begin
    if (op.ins) begin
      if (!keep) begin
        if (left_keep) begin
          entry.prio <= op.prio;
          entry.data <= op.data;
        end else begin
          entry <= left_entry;
        end
      end
    end else if (op.rem) begin
      entry <= right_entry;
    end
  end

endmodule

@@ sv/spq_checker.sv @@
// Port-level checks for the sorted priority queue and their bind to the top level.
module spq_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // A waiting result stays offered until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped before transfer");

  // No result is offered in the cycle after reset.
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result offered right after reset");

  // Only the three defined status codes appear.
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == spq_pkg::ST_DONE || m_tuser == spq_pkg::ST_FULL ||
                  m_tuser == spq_pkg::ST_EMPTY))
    else $error("undefined status code");

  // The reported count never exceeds the capacity.
  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[44:40] <= 5'(spq_pkg::DEPTH)))
    else $error("fill count above capacity");

  // A refused operation carries no entry.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != spq_pkg::ST_DONE |-> (m_tdata[39:0] == 40'd0))
    else $error("refused operation returned an entry");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

@@ sim/testbench.sv @@
// Self-checking testbench for the sorted priority queue with a shadow queue predictor.
`timescale 1ns / 100ps

module testbench;

  // One expected result, field by field.
  typedef struct packed {
    logic [1:0]                 status;
    logic [spq_pkg::PRIO_W-1:0] prio;
    logic [spq_pkg::DATA_W-1:0] data;
    logic [spq_pkg::CNT_W-1:0]  fill;
  } qresult_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // [7:0] priority_req, [39:8] payload
  logic        s_tuser;   // [0] kind
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // [7:0] out_priority, [39:8] out_payload, [44:40] fill_count
  logic [1:0]  m_tuser;   // [1:0] status

  // Shadow copy of the queue contents.
  spq_pkg::entry_t shadow_store [spq_pkg::DEPTH];
  int              shadow_head;
  int              shadow_count;
  qresult_t        expected_results [$];

  int  errors;
  bit  idle_on;
  int  n_inserted;
  int  n_refused;
  int  n_removed;
  int  n_empty_removes;

  sorted_priority_queue i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Applies one operation to the shadow queue and returns the result it must give.
  function automatic qresult_t queue_apply(logic kind, logic [spq_pkg::PRIO_W-1:0] prio,
                                           logic [spq_pkg::DATA_W-1:0] data);
    qresult_t r;
    int place;
    int k;
    r = '0;
    if (kind == spq_pkg::KIND_INSERT) begin
      if (shadow_count >= spq_pkg::DEPTH) begin
        r.status = spq_pkg::ST_FULL;
        n_refused++;
      end else begin
        // Find the slot after every entry of lower or equal priority.
        place = 0;
        while (place < shadow_count &&
               shadow_store[(shadow_head + place) % spq_pkg::DEPTH].prio <= prio)
          place++;
        for (k = shadow_count; k > place; k--)
          shadow_store[(shadow_head + k) % spq_pkg::DEPTH] =
            shadow_store[(shadow_head + k - 1) % spq_pkg::DEPTH];
        shadow_store[(shadow_head + place) % spq_pkg::DEPTH].prio = prio;
        shadow_store[(shadow_head + place) % spq_pkg::DEPTH].data = data;
        shadow_count++;
        r.status = spq_pkg::ST_DONE;
        n_inserted++;
      end
    end else if (shadow_count == 0) begin
      r.status = spq_pkg::ST_EMPTY;
      n_empty_removes++;
    end else begin
      r.status = spq_pkg::ST_DONE;
      r.prio = shadow_store[shadow_head].prio;
      r.data = shadow_store[shadow_head].data;
      shadow_head = (shadow_head + 1) % spq_pkg::DEPTH;
      shadow_count--;
      n_removed++;
    end
    r.fill = spq_pkg::CNT_W'(shadow_count);
    return r;
  endfunction

  // Sends one operation, with an optional idle burst first, and records its expected result.
  task automatic send_op(input logic kind, input logic [spq_pkg::PRIO_W-1:0] prio,
                         input logic [spq_pkg::DATA_W-1:0] data);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {data, prio};
    do @(posedge clk); while (!s_tready);
    expected_results.push_back(queue_apply(kind, prio, data));
  endtask

  // Holds the sender off until every outstanding result has arrived.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // Receiver side: random stall bursts while idling is enabled.
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // Compares each result transfer with the oldest expectation.
  always @(posedge clk) begin : result_check
    qresult_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("Result transfer with no expectation waiting: status %0d", m_tuser);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (m_tuser !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, m_tuser);
          errors++;
        end
        if (m_tdata[7:0] !== exp_r.prio) begin
          $error("out_priority: expected %0d, actual %0d", exp_r.prio, m_tdata[7:0]);
          errors++;
        end
        if (m_tdata[39:8] !== exp_r.data) begin
          $error("out_payload: expected %0d, actual %0d",
                 $signed(exp_r.data), $signed(m_tdata[39:8]));
          errors++;
        end
        if (m_tdata[44:40] !== exp_r.fill) begin
          $error("fill_count: expected %0d, actual %0d", exp_r.fill, m_tdata[44:40]);
          errors++;
        end
      end
    end
  end

  // A remove on the empty queue after reset.
  task automatic test_remove_empty();
    send_op(spq_pkg::KIND_REMOVE, 8'd0, 32'd0);
  endtask

  // Fills the queue with extreme and tied priorities, then tries two inserts too many.
  task automatic test_fill_to_full();
    int i;
    send_op(spq_pkg::KIND_INSERT, 8'hFF, 32'h7FFF_FFFF);
    send_op(spq_pkg::KIND_INSERT, 8'h00, 32'h8000_0000);
    send_op(spq_pkg::KIND_INSERT, 8'hFF, 32'hFFFF_FFFF);
    send_op(spq_pkg::KIND_INSERT, 8'h00, 32'h0000_0000);
    // Equal priorities must leave in arrival order.
    for (i = 0; i < 12; i++)
      send_op(spq_pkg::KIND_INSERT, 8'(8'h80 + (i % 3)), $urandom);
    send_op(spq_pkg::KIND_INSERT, 8'h01, 32'h1234_5678);
    send_op(spq_pkg::KIND_INSERT, 8'hFF, 32'hDEAD_BEEF);
  endtask

  // Random operations in segments that push the queue toward full and then toward empty.
  task automatic test_random_traffic(input int n_segments, input int seg_len);
    int s;
    int i;
    int insert_pct;
    logic kind;
    logic [spq_pkg::PRIO_W-1:0] prio;
    for (s = 0; s < n_segments; s++) begin
      case (s % 3)
        0: insert_pct = 75;
        1: insert_pct = 25;
        default: insert_pct = 50;
      endcase
      for (i = 0; i < seg_len; i++) begin
        kind = ($urandom_range(0, 99) < insert_pct) ? spq_pkg::KIND_INSERT
                                                     : spq_pkg::KIND_REMOVE;
        case ($urandom_range(0, 3))
          0: prio = 8'($urandom_range(0, 3));
          1: prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          default: prio = 8'($urandom);
        endcase
        send_op(kind, prio, $urandom);
      end
    end
  endtask

  // Sender pauses until everything outstanding has been returned.
  task automatic test_drained_pause();
    wait_drained();
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_back_to_back();
    idle_on = 1'b0;
    test_random_traffic(3, 80);
  endtask

  // Run-time limit.
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Reset, stimulus and final report.
  initial begin
    int c;
    errors = 0;
    idle_on = 1'b1;
    n_inserted = 0;
    n_refused = 0;
    n_removed = 0;
    n_empty_removes = 0;
    shadow_head = 0;
    shadow_count = 0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tuser  <= spq_pkg::KIND_INSERT;
    s_tdata  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_remove_empty();
    test_fill_to_full();
    test_random_traffic(7, 100);
    test_drained_pause();
    test_random_traffic(7, 100);
    test_back_to_back();

    // Let every outstanding result come back, then a few more cycles.
    s_tvalid <= 1'b0;
    for (c = 0; c < 2000 && expected_results.size() != 0; c++)
      @(posedge clk);
    repeat (4) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      errors++;
    end

    $display("Covered %0d inserts, %0d refused when full, %0d removes, %0d removes when empty.",
             n_inserted, n_refused, n_removed, n_empty_removes);
    $display("Traffic ran with random idling on both sides and back to back; %0d errors.",
             errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sorted_priority_queue.f @@
sv/spq_pkg.sv
sv/spq_cell.sv
sv/sorted_priority_queue.sv
sv/spq_checker.sv
sim/testbench.sv
